// ----- hdl/lexps_pkg.sv -----
// Types, codes and helpers shared by the leg exercise phase sequencer.
`default_nettype none
package lexps_pkg;

   // Request: one command with its timestamp and the limit switch levels.
   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now_ms;
      logic        top_switch;
      logic        bottom_switch;
   } req_type;

   // Result: the sequencer status after the command took effect.
   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] reps_done;
      logic [22:0] elapsed_seconds;
      logic [22:0] last_session_seconds;
      logic [15:0] last_session_reps;
      logic        started_flag;
      logic        stopped_flag;
   } rsp_type;

   // Status after the state update, still in milliseconds.
   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] reps_done;
      logic [31:0] elapsed_ms;
      logic [31:0] frozen_ms;
      logic [15:0] frozen_reps;
      logic        started_flag;
      logic        stopped_flag;
   } mid_type;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_LIFT  = 3'd1;
   localparam logic [2:0] PH_HOLD  = 3'd2;
   localparam logic [2:0] PH_LOWER = 3'd3;
   localparam logic [2:0] PH_REST  = 3'd4;
   localparam logic [2:0] PH_SAFE  = 3'd5;
   localparam logic [2:0] PH_FAULT = 3'd6;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;
   localparam logic [1:0] CMD_FAULT = 2'd3;

   localparam logic [1:0] REG_TRAVEL = 2'd0;
   localparam logic [1:0] REG_HOLD   = 2'd1;
   localparam logic [1:0] REG_REST   = 2'd2;

   localparam logic [31:0] TRAVEL_RESET = 32'd5000;
   localparam logic [31:0] HOLD_RESET   = 32'd2000;
   localparam logic [31:0] REST_RESET   = 32'd2000;

   localparam logic [15:0] REPS_MAX = 16'hFFFF;

   // ceil(2^38 / 1000): exact quotient by 1000 for every 32-bit value
   localparam logic [28:0] MS_DIV_MULT  = 29'd274877907;
   localparam int          MS_DIV_SHIFT = 38;

   function automatic logic [22:0] ms_to_sec(input logic [31:0] ms);
      logic [60:0] prod;
      prod = {29'd0, ms} * {32'd0, MS_DIV_MULT};
      return prod[MS_DIV_SHIFT +: 23];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/leg_exercise_phase_sequencer_core.sv -----
// Leg exercise phase sequencer: input register, state update, divide stage, result register.
//
// Requests arrive on req_valid/req_ready with a command (tick, start, stop,
// force fault), a millisecond timestamp and the two limit switch levels.
// Every accepted request yields exactly one result on rsp_valid/rsp_ready:
// the phase, repetition count, elapsed and last-session seconds and the
// started/stopped flags, all taken after the command is applied.
// Three register stages: the request register, the state update into a
// status register, and the millisecond-to-second conversion (one 32x29
// multiply per field) into the result register. An accepted request moves
// through the status and result registers to rsp_valid; one request per
// cycle is sustained while rsp_ready stays high. When the receiver stalls,
// each stage holds and fills in turn, so up to three requests are absorbed
// before req_ready drops. Synchronous reset returns the sequencer to idle
// with all counts zero and the timing registers to 5000/2000/2000 ms. These
// sit on an APB-style port at byte addresses 0, 4 and 8; the user must
// write them only while no request is in flight, which the block does not enforce.
`default_nettype none
module leg_exercise_phase_sequencer_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire lexps_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output lexps_pkg::rsp_type  rsp_data,
   input  wire                 psel,
   input  wire                 penable,
   input  wire                 pwrite,
   input  wire  [3:0]          paddr,
   input  wire  [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import lexps_pkg::*;

   // configuration
   logic [31:0] travel_ff, travel_in;
   logic [31:0] hold_ff, hold_in;
   logic [31:0] rest_ff, rest_in;

   // pipeline
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    mid_valid_ff, mid_valid_in;
   mid_type mid_data_ff, mid_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   // sequencer state
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] phase_start_ff, phase_start_in;
   logic [31:0] session_start_ff, session_start_in;
   logic [15:0] reps_ff, reps_in;
   logic [31:0] frozen_ms_ff, frozen_ms_in;
   logic [15:0] frozen_reps_ff, frozen_reps_in;

   logic        ready2, ready3, adv1, adv2, req_fire, cfg_write;
   logic        running, go, fin, start_evt, rep_inc;
   logic [2:0]  tgt, phase_new;
   logic [31:0] sess_diff, dt, session_start_new, frozen_ms_new;
   logic [15:0] reps_new, frozen_reps_new;

   // ---------------- handshake ----------------
   assign ready3    = !out_valid_ff || rsp_ready;
   assign adv2      = mid_valid_ff && ready3;
   assign ready2    = !mid_valid_ff || ready3;
   assign adv1      = in_valid_ff && ready2;
   assign req_ready = !in_valid_ff || ready2;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !adv1);
   assign mid_valid_in = adv1 || (mid_valid_ff && !adv2);
   assign out_valid_in = adv2 || (out_valid_ff && !rsp_ready);
   assign in_data_in   = req_fire ? req_data : in_data_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      travel_in = travel_ff;
      hold_in   = hold_ff;
      rest_in   = rest_ff;
      if (cfg_write) begin
         unique case (paddr[3:2])
            REG_TRAVEL: travel_in = pwdata;
            REG_HOLD:   hold_in   = pwdata;
            REG_REST:   rest_in   = pwdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_TRAVEL: prdata = travel_ff;
         REG_HOLD:   prdata = hold_ff;
         REG_REST:   prdata = rest_ff;
         default:    prdata = '0;
      endcase
   end

   // ---------------- phase sequencing ----------------
   assign running   = (phase_ff != PH_IDLE) && (phase_ff != PH_FAULT);
   assign sess_diff = in_data_ff.now_ms - session_start_ff;
   assign dt        = in_data_ff.now_ms - phase_start_ff;

   always_comb begin
      go        = 1'b0;
      fin       = 1'b0;   // session ends
      tgt       = phase_ff;
      start_evt = 1'b0;
      rep_inc   = 1'b0;
      unique case (in_data_ff.command)
         CMD_TICK: begin
            if (running && in_data_ff.top_switch && in_data_ff.bottom_switch) begin
               fin = 1'b1;
               tgt = PH_FAULT;
            end else begin
               unique case (phase_ff)
                  PH_LIFT: begin
                     if (in_data_ff.top_switch) begin
                        go  = 1'b1;
                        tgt = PH_HOLD;
                     end else if (dt >= travel_ff) begin
                        fin = 1'b1;
                        tgt = PH_FAULT;
                     end
                  end
                  PH_HOLD: begin
                     if (dt >= hold_ff) begin
                        go  = 1'b1;
                        tgt = PH_LOWER;
                     end
                  end
                  PH_LOWER: begin
                     if (in_data_ff.bottom_switch) begin
                        go  = 1'b1;
                        tgt = PH_REST;
                     end else if (dt >= travel_ff) begin
                        fin = 1'b1;
                        tgt = PH_FAULT;
                     end
                  end
                  PH_REST: begin
                     if (dt >= rest_ff) begin
                        go      = 1'b1;
                        tgt     = PH_LIFT;
                        rep_inc = 1'b1;
                     end
                  end
                  PH_SAFE: begin
                     if (in_data_ff.bottom_switch || dt >= travel_ff) begin
                        fin = 1'b1;
                        tgt = PH_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         CMD_START: begin
            if (!running) begin
               start_evt = 1'b1;
               go        = 1'b1;
               tgt       = PH_LIFT;
            end
         end
         CMD_STOP: begin
            unique case (phase_ff) inside
               PH_LIFT, PH_HOLD, PH_LOWER: begin
                  go  = 1'b1;
                  tgt = PH_SAFE;
               end
               PH_REST: begin
                  fin = 1'b1;
                  tgt = PH_IDLE;
               end
               default: ;
            endcase
         end
         CMD_FAULT: begin
            if (running) begin
               fin = 1'b1;
               tgt = PH_FAULT;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      phase_new         = (go || fin) ? tgt : phase_ff;
      session_start_new = start_evt ? in_data_ff.now_ms : session_start_ff;
      if (start_evt) begin
         reps_new = '0;
      end else if (rep_inc && reps_ff != REPS_MAX) begin
         reps_new = reps_ff + 16'd1;
      end else begin
         reps_new = reps_ff;
      end
      // a session only ends from a running phase, so the elapsed time is sess_diff
      frozen_ms_new   = fin ? sess_diff : frozen_ms_ff;
      frozen_reps_new = fin ? reps_ff : frozen_reps_ff;

      phase_in         = adv1 ? phase_new : phase_ff;
      phase_start_in   = (adv1 && (go || fin)) ? in_data_ff.now_ms : phase_start_ff;
      session_start_in = adv1 ? session_start_new : session_start_ff;
      reps_in          = adv1 ? reps_new : reps_ff;
      frozen_ms_in     = adv1 ? frozen_ms_new : frozen_ms_ff;
      frozen_reps_in   = adv1 ? frozen_reps_new : frozen_reps_ff;
   end

   always_comb begin
      mid_data_in = mid_data_ff;
      if (adv1) begin
         mid_data_in.phase        = phase_new;
         mid_data_in.reps_done    = reps_new;
         mid_data_in.frozen_ms    = frozen_ms_new;
         mid_data_in.frozen_reps  = frozen_reps_new;
         mid_data_in.started_flag = start_evt;
         mid_data_in.stopped_flag = fin;
         if (phase_new == PH_IDLE) begin
            mid_data_in.elapsed_ms = '0;
         end else if (phase_new == PH_FAULT) begin
            mid_data_in.elapsed_ms = frozen_ms_new;
         end else begin
            mid_data_in.elapsed_ms = start_evt ? 32'd0 : sess_diff;
         end
      end
   end

   // ---------------- seconds conversion ----------------
   always_comb begin
      out_data_in = out_data_ff;
      if (adv2) begin
         out_data_in.phase                = mid_data_ff.phase;
         out_data_in.reps_done            = mid_data_ff.reps_done;
         out_data_in.elapsed_seconds      = ms_to_sec(mid_data_ff.elapsed_ms);
         out_data_in.last_session_seconds = ms_to_sec(mid_data_ff.frozen_ms);
         out_data_in.last_session_reps    = mid_data_ff.frozen_reps;
         out_data_in.started_flag         = mid_data_ff.started_flag;
         out_data_in.stopped_flag         = mid_data_ff.stopped_flag;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         travel_ff        <= TRAVEL_RESET;
         hold_ff          <= HOLD_RESET;
         rest_ff          <= REST_RESET;
         in_valid_ff      <= 1'b0;
         mid_valid_ff     <= 1'b0;
         out_valid_ff     <= 1'b0;
         phase_ff         <= PH_IDLE;
         phase_start_ff   <= '0;
         session_start_ff <= '0;
         reps_ff          <= '0;
         frozen_ms_ff     <= '0;
         frozen_reps_ff   <= '0;
      end else begin
         travel_ff        <= travel_in;
         hold_ff          <= hold_in;
         rest_ff          <= rest_in;
         in_valid_ff      <= in_valid_in;
         mid_valid_ff     <= mid_valid_in;
         out_valid_ff     <= out_valid_in;
         phase_ff         <= phase_in;
         phase_start_ff   <= phase_start_in;
         session_start_ff <= session_start_in;
         reps_ff          <= reps_in;
         frozen_ms_ff     <= frozen_ms_in;
         frozen_reps_ff   <= frozen_reps_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      mid_data_ff <= mid_data_in;
      out_data_ff <= out_data_in;
   end

endmodule
`default_nettype wire

// ----- hdl/lexps_checker.sv -----
// Port-level checks for the leg exercise phase sequencer, bound to the top level.
`default_nettype none
module lexps_checker (
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire lexps_pkg::rsp_type rsp_data
);
   import lexps_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase == PH_IDLE |-> rsp_data.elapsed_seconds == 23'd0)
      else $error("idle result with nonzero elapsed time");

   a_fault_frozen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase == PH_FAULT
         |-> rsp_data.elapsed_seconds == rsp_data.last_session_seconds)
      else $error("fault result does not show the frozen time");

   a_start_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.started_flag
         |-> rsp_data.phase == PH_LIFT && rsp_data.reps_done == 16'd0
             && rsp_data.elapsed_seconds == 23'd0)
      else $error("start did not open a fresh session");

   a_stop_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stopped_flag
         |-> rsp_data.phase == PH_IDLE || rsp_data.phase == PH_FAULT)
      else $error("session end left the leg running");

endmodule

bind leg_exercise_phase_sequencer_core lexps_checker u_lexps_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ----- verif/leg_exercise_phase_sequencer_core_test.sv -----
// Self-checking testbench for the leg exercise phase sequencer core.
module leg_exercise_phase_sequencer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lexps_pkg::*;

   localparam int          CYCLE_LIMIT = 2_000_000;
   localparam logic [31:0] MS_PER_SEC  = 32'd1000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   leg_exercise_phase_sequencer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   int      error_count = 0;
   int      cycle_count;
   logic    sender_idle_on = 1'b1;
   logic    receiver_stall_on = 1'b1;
   logic [31:0] wall_ms = '0;
   rsp_type pending_status[$];

   // sequencer shadow: timing registers and session state
   logic [31:0] travel_ms, hold_ms, rest_ms;
   logic [2:0]  seq_phase;
   logic [31:0] phase_mark_ms, session_mark_ms;
   logic [15:0] rep_count, frozen_reps;
   logic [22:0] frozen_secs;
   logic        started_pend, stopped_pend;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 50) $display("%0t ns mismatch: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   function automatic void reset_sequencer_model();
      travel_ms       = TRAVEL_RESET;
      hold_ms         = HOLD_RESET;
      rest_ms         = REST_RESET;
      seq_phase       = PH_IDLE;
      phase_mark_ms   = '0;
      session_mark_ms = '0;
      rep_count       = '0;
      frozen_secs     = '0;
      frozen_reps     = '0;
      started_pend    = 1'b0;
      stopped_pend    = 1'b0;
   endfunction

   function automatic logic [22:0] whole_seconds(input logic [31:0] from_ms,
                                                 input logic [31:0] to_ms);
      logic [31:0] span;
      span = to_ms - from_ms;
      return 23'(span / MS_PER_SEC);
   endfunction

   function automatic void enter_phase(input logic [2:0] next_phase,
                                       input logic [31:0] at_ms);
      seq_phase     = next_phase;
      phase_mark_ms = at_ms;
   endfunction

   function automatic void close_session(input logic [31:0] at_ms,
                                         input logic [2:0] next_phase);
      frozen_secs  = (seq_phase == PH_IDLE) ? 23'd0 : whole_seconds(session_mark_ms, at_ms);
      frozen_reps  = rep_count;
      stopped_pend = 1'b1;
      enter_phase(next_phase, at_ms);
   endfunction

   // Applies one request to the shadow state and returns the status it reports.
   function automatic rsp_type predict_status(input req_type r);
      rsp_type     s;
      logic [31:0] dt;
      logic        running;
      running = (seq_phase != PH_IDLE) && (seq_phase != PH_FAULT);
      dt = r.now_ms - phase_mark_ms;
      case (r.command)
         CMD_TICK: begin
            if (running && r.top_switch && r.bottom_switch) begin
               close_session(r.now_ms, PH_FAULT);
            end else begin
               case (seq_phase)
                  PH_LIFT: begin
                     if (r.top_switch) enter_phase(PH_HOLD, r.now_ms);
                     else if (dt >= travel_ms) close_session(r.now_ms, PH_FAULT);
                  end
                  PH_HOLD: begin
                     if (dt >= hold_ms) enter_phase(PH_LOWER, r.now_ms);
                  end
                  PH_LOWER: begin
                     if (r.bottom_switch) enter_phase(PH_REST, r.now_ms);
                     else if (dt >= travel_ms) close_session(r.now_ms, PH_FAULT);
                  end
                  PH_REST: begin
                     if (dt >= rest_ms) begin
                        if (rep_count != REPS_MAX) rep_count++;
                        enter_phase(PH_LIFT, r.now_ms);
                     end
                  end
                  PH_SAFE: begin
                     if (r.bottom_switch || dt >= travel_ms) close_session(r.now_ms, PH_IDLE);
                  end
                  default: ;
               endcase
            end
         end
         CMD_START: begin
            if (!running) begin
               session_mark_ms = r.now_ms;
               rep_count       = '0;
               started_pend    = 1'b1;
               enter_phase(PH_LIFT, r.now_ms);
            end
         end
         CMD_STOP: begin
            if (seq_phase == PH_LIFT || seq_phase == PH_HOLD || seq_phase == PH_LOWER)
               enter_phase(PH_SAFE, r.now_ms);
            else if (seq_phase == PH_REST)
               close_session(r.now_ms, PH_IDLE);
         end
         default: begin
            if (running) close_session(r.now_ms, PH_FAULT);
         end
      endcase
      s.phase     = seq_phase;
      s.reps_done = rep_count;
      if (seq_phase == PH_IDLE) s.elapsed_seconds = '0;
      else if (seq_phase == PH_FAULT) s.elapsed_seconds = frozen_secs;
      else s.elapsed_seconds = whole_seconds(session_mark_ms, r.now_ms);
      s.last_session_seconds = frozen_secs;
      s.last_session_reps    = frozen_reps;
      s.started_flag         = started_pend;
      s.stopped_flag         = stopped_pend;
      started_pend = 1'b0;
      stopped_pend = 1'b0;
      return s;
   endfunction

   function automatic req_type make_request(input logic [1:0] cmd, input logic [31:0] at_ms,
                                            input logic top, input logic bottom);
      req_type r;
      r.command       = cmd;
      r.now_ms        = at_ms;
      r.top_switch    = top;
      r.bottom_switch = bottom;
      return r;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      else if (pick < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = sender_idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_status.push_back(predict_status(r));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_read(input logic [1:0] idx, output logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      value = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      case (idx)
         REG_TRAVEL: travel_ms = value;
         REG_HOLD:   hold_ms   = value;
         REG_REST:   rest_ms   = value;
         default: ;
      endcase
      csr_read(idx, readback);
      compare_field($sformatf("register %0d readback", idx), readback, value);
   endtask

   task automatic set_timing(input logic [31:0] travel, input logic [31:0] hold,
                             input logic [31:0] rest);
      csr_write(REG_TRAVEL, travel);
      csr_write(REG_HOLD, hold);
      csr_write(REG_REST, rest);
   endtask

   // Random request steered by the shadow phase so that sessions run deep.
   function automatic req_type next_random_request();
      req_type     r;
      int          pick;
      logic [31:0] span;
      logic        running;
      running = (seq_phase != PH_IDLE) && (seq_phase != PH_FAULT);
      pick = $urandom_range(0, 99);
      if (running)
         r.command = (pick < 85) ? CMD_TICK : (pick < 89) ? CMD_START :
                     (pick < 95) ? CMD_STOP : CMD_FAULT;
      else
         r.command = (pick < 45) ? CMD_START : (pick < 75) ? CMD_TICK :
                     (pick < 88) ? CMD_STOP : CMD_FAULT;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // land on, just short of, or just past a timing boundary
         case ($urandom_range(0, 2))
            0:       span = travel_ms;
            1:       span = hold_ms;
            default: span = rest_ms;
         endcase
         wall_ms = phase_mark_ms + span + 32'($urandom_range(0, 2)) - 32'd1;
      end else begin
         if (pick < 15) span = '0;
         else if (pick < 18) span = '1;
         else if (pick < 24) span = $urandom;
         else if (pick < 50) span = $urandom_range(0, 300);
         else span = $urandom_range(0, 6000);
         wall_ms = wall_ms + span;
      end
      r.now_ms        = wall_ms;
      r.top_switch    = (seq_phase == PH_LIFT) ? ($urandom_range(0, 9) < 4)
                                               : ($urandom_range(0, 99) < 8);
      r.bottom_switch = (seq_phase == PH_LOWER || seq_phase == PH_SAFE)
                        ? ($urandom_range(0, 9) < 4) : ($urandom_range(0, 99) < 8);
      return r;
   endfunction

   task automatic test_register_reset();
      logic [31:0] value;
      csr_read(REG_TRAVEL, value);
      compare_field("travel limit after reset", value, TRAVEL_RESET);
      csr_read(REG_HOLD, value);
      compare_field("hold time after reset", value, HOLD_RESET);
      csr_read(REG_REST, value);
      compare_field("rest time after reset", value, REST_RESET);
   endtask

   task automatic test_directed_phases();
      // idle ignores both switches, stop and force fault
      send_request(make_request(CMD_TICK, 32'd0, 1'b1, 1'b1));
      send_request(make_request(CMD_STOP, 32'hFFFF_FFFF, 1'b0, 1'b0));
      send_request(make_request(CMD_FAULT, 32'h7FFF_FFFF, 1'b1, 1'b0));
      // full repetition, then stop while resting
      send_request(make_request(CMD_START, 32'd1000, 1'b0, 1'b1));
      send_request(make_request(CMD_START, 32'd1500, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd2500, 1'b1, 1'b0));
      send_request(make_request(CMD_TICK, 32'd4499, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd4500, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd5000, 1'b0, 1'b1));
      send_request(make_request(CMD_TICK, 32'd7000, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd7100, 1'b1, 1'b0));
      send_request(make_request(CMD_TICK, 32'd9100, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd9200, 1'b0, 1'b1));
      send_request(make_request(CMD_STOP, 32'd9300, 1'b0, 1'b0));
      // lift timeout across the millisecond wrap; fault ignores stop and fault
      send_request(make_request(CMD_START, 32'hFFFF_F000, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'h0000_0388, 1'b0, 1'b0));
      send_request(make_request(CMD_STOP, 32'h0000_0400, 1'b0, 1'b0));
      send_request(make_request(CMD_FAULT, 32'h0000_0500, 1'b0, 1'b0));
      // wiring fault
      send_request(make_request(CMD_START, 32'd1000, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd1200, 1'b1, 1'b1));
      // stop in lift, stop again in safe lower, safe lower times out
      send_request(make_request(CMD_START, 32'd2000, 1'b0, 1'b0));
      send_request(make_request(CMD_STOP, 32'd2100, 1'b0, 1'b0));
      send_request(make_request(CMD_STOP, 32'd2200, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd7100, 1'b0, 1'b0));
      // stop in hold, safe lower reaches the bottom
      send_request(make_request(CMD_START, 32'd8000, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd8100, 1'b1, 1'b0));
      send_request(make_request(CMD_STOP, 32'd8200, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd8300, 1'b0, 1'b1));
      // forced fault, then lower timeout
      send_request(make_request(CMD_START, 32'd9000, 1'b0, 1'b0));
      send_request(make_request(CMD_FAULT, 32'd9500, 1'b0, 1'b0));
      send_request(make_request(CMD_START, 32'd10000, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd10001, 1'b1, 1'b0));
      send_request(make_request(CMD_TICK, 32'd12001, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 32'd17001, 1'b0, 1'b0));
      drain_results();
   endtask

   // Zero hold and rest times give one repetition per four ticks; no gaps on either side.
   task automatic test_back_to_back_reps();
      logic [31:0] stamp;
      drain_results();
      set_timing(32'hFFFF_FFFF, 32'd0, 32'd0);
      sender_idle_on    = 1'b0;
      receiver_stall_on = 1'b0;
      stamp = 32'd0;
      send_request(make_request(CMD_START, stamp, 1'b0, 1'b0));
      for (int rep = 0; rep < 40; rep++) begin
         send_request(make_request(CMD_TICK, stamp + 32'd1, 1'b1, 1'b0));
         send_request(make_request(CMD_TICK, stamp + 32'd2, 1'b0, 1'b0));
         send_request(make_request(CMD_TICK, stamp + 32'd3, 1'b0, 1'b1));
         send_request(make_request(CMD_TICK, stamp + 32'd4, 1'b0, 1'b0));
         stamp = stamp + 32'd4;
      end
      send_request(make_request(CMD_STOP, stamp + 32'd1, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, stamp + 32'd2, 1'b0, 1'b1));
      drain_results();
      sender_idle_on    = 1'b1;
      receiver_stall_on = 1'b1;
   endtask

   task automatic test_random_sessions(input int total);
      int per_setting;
      per_setting = total / 8;
      for (int setting = 0; setting < 8; setting++) begin
         drain_results();
         case (setting)
            3:       set_timing(32'd0, 32'd0, 32'd0);
            4:       set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            5:       set_timing($urandom, 32'd0, 32'hFFFF_FFFF);
            6:       set_timing(32'd0, 32'hFFFF_FFFF, $urandom_range(0, 3000));
            default: set_timing($urandom_range(500, 8000), $urandom_range(0, 4000),
                                 $urandom_range(0, 4000));
         endcase
         sender_idle_on    = (setting != 2);
         receiver_stall_on = (setting != 2) && (setting != 5);
         for (int i = 0; i < per_setting; i++) begin
            if ($urandom_range(0, 99) == 0) drain_results();
            send_request(next_random_request());
         end
      end
      drain_results();
   endtask

   // receiver stalls: ready runs of random length
   initial begin
      int run_left;
      int pick;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (run_left > 0) begin
            run_left--;
         end else if (!receiver_stall_on) begin
            rsp_ready = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_ready = 1'b1;
               run_left  = $urandom_range(0, 6);
            end else if (pick < 90) begin
               rsp_ready = 1'b0;
               run_left  = $urandom_range(0, 2);
            end else begin
               rsp_ready = 1'b0;
               run_left  = $urandom_range(8, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_status.pop_front();
            compare_field("phase", 32'(rsp_data.phase), 32'(want.phase));
            compare_field("reps_done", 32'(rsp_data.reps_done), 32'(want.reps_done));
            compare_field("elapsed_seconds", 32'(rsp_data.elapsed_seconds),
                          32'(want.elapsed_seconds));
            compare_field("last_session_seconds", 32'(rsp_data.last_session_seconds),
                          32'(want.last_session_seconds));
            compare_field("last_session_reps", 32'(rsp_data.last_session_reps),
                          32'(want.last_session_reps));
            compare_field("started_flag", 32'(rsp_data.started_flag),
                          32'(want.started_flag));
            compare_field("stopped_flag", 32'(rsp_data.stopped_flag),
                          32'(want.stopped_flag));
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** leg_exercise_phase_sequencer_core: FAILED **");
      $finish;
   end

   initial begin
      reset_sequencer_model();
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_register_reset();
      test_directed_phases();
      test_back_to_back_reps();
      test_random_sessions(1300);
      drain_results();
      if (error_count == 0) begin
         $display("** leg_exercise_phase_sequencer_core: PASSED **");
      end else begin
         $display("** leg_exercise_phase_sequencer_core: FAILED **");
      end
      $finish;
   end

endmodule
